>>> hdl/vector3_normalize_core_macros.svh
// Assertion macros used by the vector normalizer checker
`ifndef VECTOR3_NORMALIZE_CORE_MACROS_SVH
`define VECTOR3_NORMALIZE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define VN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge
`define VN_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/vn_pkg.sv
// Types and constants shared by the vector normalizer
package vn_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned UNIT_FRAC = 30;
  localparam int unsigned SUM_W     = 2 * WORD_W;
  localparam int unsigned ROOT_W    = SUM_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 1;
  localparam int unsigned QUO_W     = UNIT_FRAC + 1;
  localparam int unsigned LANES     = 3;

  typedef struct packed {
    logic [LANES-1:0]             neg;
    logic                         zero;
    logic [LANES-1:0][WORD_W-1:0] mag;
  } vn_tag_t;

endpackage

>>> hdl/vn_stream_if.sv
// Valid/ready stream interfaces for vector beats and unit vector beats
interface vn_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [vn_pkg::WORD_W-1:0]   comp_x;
  logic signed [vn_pkg::WORD_W-1:0]   comp_y;
  logic signed [vn_pkg::WORD_W-1:0]   comp_z;

  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [vn_pkg::WORD_W-1:0]   unit_x;
  logic signed [vn_pkg::WORD_W-1:0]   unit_y;
  logic signed [vn_pkg::WORD_W-1:0]   unit_z;
  logic        [vn_pkg::WORD_W-1:0]   length;
  logic                               zero_vector;

  modport source (output valid, unit_x, unit_y, unit_z, length, zero_vector, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, length, zero_vector, output ready);
endinterface

>>> hdl/vector3_normalize_core.sv
// Normaliser top level: Q16.16 vector in, Q2.30 unit vector and length out
//
// Takes one vector beat per cycle while the output is not held and returns
// one result beat per vector, in order. A beat passes through an absolute
// value stage, a square stage, a sum stage, the 32-stage square root
// pipeline (one root bit per stage), the 31-stage divide pipeline (one
// quotient bit per stage) and the output register. All stages advance
// together: while the output register holds a beat that is not taken, the
// whole pipeline holds and no input is taken.
// A zero vector gives zero_vector high with zero length and components.
module vector3_normalize_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  vn_in_if.sink    in_i,
  vn_out_if.source out_o
);
  import vn_pkg::*;

  logic                         adv;
  logic                         out_valid_q;

  logic                         s1_valid_q;
  vn_tag_t                      s1_tag_q;
  logic                         s2_valid_q;
  vn_tag_t                      s2_tag_q;
  logic [LANES-1:0][SUM_W-1:0]  s2_sq_q;
  logic                         s3_valid_q;
  vn_tag_t                      s3_tag_q;
  logic [SUM_W-1:0]             s3_sum_q;

  logic                         rt_valid;
  logic [ROOT_W-1:0]            rt_root;
  vn_tag_t                      rt_tag;
  logic                         dv_valid;
  logic [ROOT_W-1:0]            dv_root;
  vn_tag_t                      dv_tag;
  logic [LANES-1:0][QUO_W-1:0]  dv_quo;

  vn_tag_t                      s1_tag_d;
  logic [LANES-1:0][WORD_W-1:0] comp;
  logic [LANES-1:0][WORD_W-1:0] unit_d;
  logic [LANES-1:0][WORD_W-1:0] unit_q;
  logic [WORD_W-1:0]            length_q;
  logic                         zero_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  assign comp = {in_i.comp_z, in_i.comp_y, in_i.comp_x};

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s1_tag_d.neg[l] = comp[l][WORD_W-1];
      s1_tag_d.mag[l] = comp[l][WORD_W-1] ? WORD_W'(~comp[l] + 1'b1) : comp[l];
    end
    s1_tag_d.zero = (comp == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q <= s1_tag_d;
      s2_tag_q <= s1_tag_q;
      for (int l = 0; l < LANES; l++) begin
        s2_sq_q[l] <= SUM_W'(s1_tag_q.mag[l]) * SUM_W'(s1_tag_q.mag[l]);
      end
      s3_tag_q <= s2_tag_q;
      s3_sum_q <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
    end
  end

  vn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s3_valid_q),
    .sum_i   (s3_sum_q),
    .tag_i   (s3_tag_q),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .tag_o   (rt_tag)
  );

  vn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (rt_valid),
    .root_i  (rt_root),
    .tag_i   (rt_tag),
    .valid_o (dv_valid),
    .root_o  (dv_root),
    .tag_o   (dv_tag),
    .quo_o   (dv_quo)
  );

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dv_tag.zero) begin
        unit_d[l] = '0;
      end else if (dv_tag.neg[l]) begin
        unit_d[l] = WORD_W'(-{1'b0, dv_quo[l]});
      end else begin
        unit_d[l] = WORD_W'({1'b0, dv_quo[l]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unit_q   <= unit_d;
      length_q <= dv_tag.zero ? '0 : dv_root;
      zero_q   <= dv_tag.zero;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.unit_x      = unit_q[0];
  assign out_o.unit_y      = unit_q[1];
  assign out_o.unit_z      = unit_q[2];
  assign out_o.length      = length_q;
  assign out_o.zero_vector = zero_q;

endmodule

>>> hdl/vn_isqrt.sv
// Pipelined integer square root, one result bit per stage
module vn_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [vn_pkg::SUM_W-1:0]    sum_i,
  input  vn_pkg::vn_tag_t             tag_i,
  output logic                        valid_o,
  output logic [vn_pkg::ROOT_W-1:0]   root_o,
  output vn_pkg::vn_tag_t             tag_o
);
  import vn_pkg::*;

  localparam int unsigned STAGES = ROOT_W;

  logic                     valid_q [STAGES];
  logic [SUM_W-1:0]         rad_q   [STAGES];
  logic [REM_W-1:0]         rem_q   [STAGES];
  logic [ROOT_W-1:0]        root_q  [STAGES];
  vn_tag_t                  tag_q   [STAGES];

  logic                     valid_in [STAGES];
  logic [SUM_W-1:0]         rad_in   [STAGES];
  logic [REM_W-1:0]         rem_in   [STAGES];
  logic [ROOT_W-1:0]        root_in  [STAGES];
  vn_tag_t                  tag_in   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign valid_in[s] = valid_i;
      assign rad_in[s]   = sum_i;
      assign rem_in[s]   = '0;
      assign root_in[s]  = '0;
      assign tag_in[s]   = tag_i;
    end else begin : g_next
      assign valid_in[s] = valid_q[s-1];
      assign rad_in[s]   = rad_q[s-1];
      assign rem_in[s]   = rem_q[s-1];
      assign root_in[s]  = root_q[s-1];
      assign tag_in[s]   = tag_q[s-1];
    end

    assign rem_sh = {rem_in[s], rad_in[s][SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_in[s], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv_i) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rad_q[s]  <= {rad_in[s][SUM_W-3:0], 2'b00};
        rem_q[s]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_q[s] <= {root_in[s][ROOT_W-2:0], ge};
        tag_q[s]  <= tag_in[s];
      end
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign root_o  = root_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];

endmodule

>>> hdl/vn_div.sv
// Pipelined restoring divide of three magnitudes by the length
module vn_div (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        adv_i,
  input  logic                                        valid_i,
  input  logic [vn_pkg::ROOT_W-1:0]                   root_i,
  input  vn_pkg::vn_tag_t                             tag_i,
  output logic                                        valid_o,
  output logic [vn_pkg::ROOT_W-1:0]                   root_o,
  output vn_pkg::vn_tag_t                             tag_o,
  output logic [vn_pkg::LANES-1:0][vn_pkg::QUO_W-1:0] quo_o
);
  import vn_pkg::*;

  localparam int unsigned STAGES = QUO_W;

  logic                              valid_q [STAGES];
  logic [ROOT_W-1:0]                 root_q  [STAGES];
  vn_tag_t                           tag_q   [STAGES];
  logic [LANES-1:0][ROOT_W-1:0]      rem_q   [STAGES];
  logic [LANES-1:0][QUO_W-1:0]       quo_q   [STAGES];

  logic                              valid_in [STAGES];
  logic [ROOT_W-1:0]                 root_in  [STAGES];
  vn_tag_t                           tag_in   [STAGES];
  logic [LANES-1:0][ROOT_W-1:0]      rem_in   [STAGES];
  logic [LANES-1:0][QUO_W-1:0]       quo_in   [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [LANES-1:0][ROOT_W:0]   sh;
    logic [LANES-1:0]             ge;
    logic [LANES-1:0][ROOT_W-1:0] rem_d;
    logic [LANES-1:0][QUO_W-1:0]  quo_d;

    if (s == 0) begin : g_first
      assign valid_in[s] = valid_i;
      assign root_in[s]  = root_i;
      assign tag_in[s]   = tag_i;
      assign rem_in[s]   = tag_i.mag;
      assign quo_in[s]   = '0;
    end else begin : g_next
      assign valid_in[s] = valid_q[s-1];
      assign root_in[s]  = root_q[s-1];
      assign tag_in[s]   = tag_q[s-1];
      assign rem_in[s]   = rem_q[s-1];
      assign quo_in[s]   = quo_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (s == 0) begin : g_noshift
        assign sh[l] = {1'b0, rem_in[s][l]};
      end else begin : g_shift
        assign sh[l] = {rem_in[s][l], 1'b0};
      end
      assign ge[l]    = sh[l] >= {1'b0, root_in[s]};
      assign rem_d[l] = ge[l] ? ROOT_W'(sh[l] - {1'b0, root_in[s]}) : ROOT_W'(sh[l]);
      assign quo_d[l] = {quo_in[s][l][QUO_W-2:0], ge[l]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv_i) begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        root_q[s] <= root_in[s];
        tag_q[s]  <= tag_in[s];
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
      end
    end
  end

  assign valid_o = valid_q[STAGES-1];
  assign root_o  = root_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];
  assign quo_o   = quo_q[STAGES-1];

endmodule

>>> hdl/vn_chk.sv
// Port checker for the vector normaliser and its bind
`include "vector3_normalize_core_macros.svh"

module vn_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [vn_pkg::WORD_W-1:0] unit_x_i,
  input logic [vn_pkg::WORD_W-1:0] unit_y_i,
  input logic [vn_pkg::WORD_W-1:0] unit_z_i,
  input logic [vn_pkg::WORD_W-1:0] length_i,
  input logic                      zero_vector_i
);
  import vn_pkg::*;

  logic signed [WORD_W-1:0] ux;
  assign ux = unit_x_i;

  `VN_ASSERT_IMPL(a_hold, out_valid_i && !out_ready_i, ##1 out_valid_i, "result beat dropped")
  `VN_ASSERT_IMPL(a_stall, out_valid_i && !out_ready_i, !in_ready_i, "input taken while held")
  `VN_ASSERT_IMPL(a_zero, out_valid_i && zero_vector_i,
                  length_i == '0 && unit_x_i == '0 && unit_y_i == '0 && unit_z_i == '0,
                  "zero vector with nonzero fields")
  `VN_ASSERT_IMPL(a_range, out_valid_i,
                  ux <= $signed(32'h4000_0000) && ux >= $signed(32'hC000_0000),
                  "unit x out of range")

endmodule

bind vector3_normalize_core vn_chk u_vn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .unit_x_i      (out_o.unit_x),
  .unit_y_i      (out_o.unit_y),
  .unit_z_i      (out_o.unit_z),
  .length_i      (out_o.length),
  .zero_vector_i (out_o.zero_vector)
);
